[rtl/core/ntc_pkg.sv]
// ntc_pkg: shared types, constants and the resistance table for the thermistor core
// used by ntc_divider and ntc_thermistor_temperature_core; no dependencies
`default_nettype none

package ntc_pkg;

  // divider widths: dividend covers r_fixed * mv, divisor covers the widest table span
  localparam int unsigned DIV_W = 30;
  localparam int unsigned DVS_W = 18;

  // resistance table geometry
  localparam int unsigned ROM_IDX_W = 6;
  localparam int unsigned ROM_W     = 18;

  // temperature scale in tenths of a degree
  localparam int unsigned TEMP_W       = 12;
  localparam logic [11:0] START_DECI_C = 12'hE70;  // -40.0 C
  localparam logic [11:0] STEP_DECI_C  = 12'd50;
  localparam int unsigned FRAC_W       = 6;

  // field widths
  localparam int unsigned SUPPLY_W = 13;
  localparam int unsigned RFIX_W   = 17;
  localparam int unsigned MV_W     = 14;

  // register indexes on the config port
  localparam logic REG_SUPPLY = 1'b0;
  localparam logic REG_RFIXED = 1'b1;

  // reset values of the registers
  localparam logic [12:0] SUPPLY_RST = 13'd3300;
  localparam logic [16:0] RFIXED_RST = 17'd10000;

  // request to the shared divider
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
  } div_req_t;

  // status and result from the shared divider
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_W-1:0]   quotient;
  } div_rsp_t;

  // descending thermistor resistance, -40 C in steps of 5 C; unused slots read 0
  function automatic logic [ROM_W-1:0] rom_ohms(input logic [ROM_IDX_W-1:0] idx);
    logic [ROM_W-1:0] val;
    case (idx)
      6'd0:    val = 18'd235831;
      6'd1:    val = 18'd173946;
      6'd2:    val = 18'd129917;
      6'd3:    val = 18'd98180;
      6'd4:    val = 18'd75022;
      6'd5:    val = 18'd57926;
      6'd6:    val = 18'd45168;
      6'd7:    val = 18'd35548;
      6'd8:    val = 18'd28224;
      6'd9:    val = 18'd22595;
      6'd10:   val = 18'd18231;
      6'd11:   val = 18'd14820;
      6'd12:   val = 18'd12133;
      6'd13:   val = 18'd10000;
      6'd14:   val = 18'd8295;
      6'd15:   val = 18'd6922;
      6'd16:   val = 18'd5810;
      6'd17:   val = 18'd4903;
      6'd18:   val = 18'd4160;
      6'd19:   val = 18'd3547;
      6'd20:   val = 18'd3039;
      6'd21:   val = 18'd2616;
      6'd22:   val = 18'd2261;
      6'd23:   val = 18'd1963;
      6'd24:   val = 18'd1711;
      6'd25:   val = 18'd1497;
      6'd26:   val = 18'd1315;
      6'd27:   val = 18'd1158;
      6'd28:   val = 18'd1024;
      6'd29:   val = 18'd909;
      6'd30:   val = 18'd809;
      6'd31:   val = 18'd722;
      6'd32:   val = 18'd646;
      6'd33:   val = 18'd580;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ntc_divider.sv]
// ntc_divider: restoring unsigned divider, one quotient bit per cycle
// depends on ntc_pkg for widths and the request/response structs
`default_nettype none

module ntc_divider
  import ntc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;

  // trial subtract of the shifted remainder
  logic [DVS_W:0] trial;
  logic           fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  // step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_W-2:0], fits};
      rem_d = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath flops
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

[rtl/core/ntc_thermistor_temperature_core.sv]
// ntc_thermistor_temperature_core: adc count to millivolts, ohms and temperature
// depends on ntc_pkg and ntc_divider
`default_nettype none

// One item at a time: an accepted adc count becomes millivolts, then the
// thermistor resistance through a serial divide, then a walk of the
// resistance table one interval per cycle, and finally a second divide on
// the shared divider that interpolates the temperature. When the voltage
// is out of range, ST_MUL passes the sample straight to ST_DONE.
// in_stall_o is high from acceptance until the result is loaded
// into the output register, which may still hold the previous unclaimed result
// while the next sample is computed. A failed table lookup keeps the last
// temperature with temperature_valid_o low; a voltage out of range reports
// ohms as -1 and clears the held temperature. No clearing pass after reset.

module ntc_thermistor_temperature_core
  import ntc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 34
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input item
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] adc_count_i,
  // result item
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [13:0]      sample_millivolts_o,
  output logic signed [29:0]      thermistor_ohms_o,
  output logic signed [11:0]      temperature_deci_c_o,
  output logic                    temperature_valid_o,
  // config port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES - 1) : 1;
  localparam logic [ROM_IDX_W-1:0] LAST_ROM = ROM_IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0]     LAST_SEG = IDX_W'(TABLE_ENTRIES - 2);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL   = 8'b0000_0010,
    ST_DIV1  = 8'b0000_0100,
    ST_CHECK = 8'b0000_1000,
    ST_WALK  = 8'b0001_0000,
    ST_FRAC  = 8'b0010_0000,
    ST_DIV2  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [SUPPLY_W-1:0] supply_q;
  logic [RFIX_W-1:0]   rfixed_q;
  logic                cfg_wr;

  // per-item working registers
  logic signed [MV_W-1:0] mv_q, mv_d;
  logic [DIV_W-1:0]       ohms_q, ohms_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [ROM_W-1:0]       pos_q, pos_d;
  logic [ROM_W-1:0]       span_q, span_d;
  logic [FRAC_W-1:0]      frac_q, frac_d;
  logic                   range_ok_q, range_ok_d;
  logic                   lookup_ok_q, lookup_ok_d;
  logic [TEMP_W-1:0]      held_q, held_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [MV_W-1:0]        out_mv_q;
  logic [DIV_W-1:0]       out_ohms_q;
  logic [TEMP_W-1:0]      out_temp_q;
  logic                   out_tv_q;
  logic                   out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // config write and read
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= SUPPLY_RST;
      rfixed_q <= RFIXED_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SUPPLY: supply_q <= pwdata[SUPPLY_W-1:0];
        REG_RFIXED: rfixed_q <= pwdata[RFIX_W-1:0];
        default:    supply_q <= supply_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SUPPLY: prdata = 32'(supply_q);
      REG_RFIXED: prdata = 32'(rfixed_q);
      default:    prdata = '0;
    endcase
  end

  // millivolts: count/8 rounded half away from zero
  logic [16:0]    cnt_abs;
  logic [13:0]    mv_mag;
  logic [MV_W-1:0] mv_in;

  assign cnt_abs = adc_count_i[15] ? 17'(-$signed({adc_count_i[15], adc_count_i}))
                                   : 17'({1'b0, adc_count_i});
  assign mv_mag  = 14'((cnt_abs + 17'd4) >> 3);
  assign mv_in   = adc_count_i[15] ? 14'(-mv_mag) : mv_mag;

  // range check and divide operands
  logic                in_range;
  logic [SUPPLY_W-1:0] mv_pos;

  assign mv_pos   = mv_q[SUPPLY_W-1:0];
  assign in_range = (mv_q > 14'sd0) && (mv_pos < supply_q);

  // table reads for the bounds check and the current interval
  logic [ROM_W-1:0] rom_first, rom_last, rom_hi, rom_lo;
  logic             seg_hit;

  assign rom_first = rom_ohms('0);
  assign rom_last  = rom_ohms(LAST_ROM);
  assign rom_hi    = rom_ohms(ROM_IDX_W'(idx_q));
  assign rom_lo    = rom_ohms(ROM_IDX_W'(idx_q) + 1'b1);
  assign seg_hit   = (ohms_q <= DIV_W'(rom_hi)) && (ohms_q >= DIV_W'(rom_lo))
                   && (rom_hi > rom_lo);

  // interpolated temperature, wraps to 12 bits
  logic [TEMP_W-1:0] temp_calc;
  assign temp_calc = START_DECI_C + TEMP_W'(TEMP_W'(idx_q) * STEP_DECI_C)
                   + TEMP_W'(frac_q);

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d      = state_q;
    mv_d         = mv_q;
    ohms_d       = ohms_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    span_d       = span_q;
    frac_d       = frac_q;
    range_ok_d   = range_ok_q;
    lookup_ok_d  = lookup_ok_q;
    div_req      = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mv_d    = mv_in;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        range_ok_d  = in_range;
        lookup_ok_d = 1'b0;
        if (in_range) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(rfixed_q * mv_pos);
          div_req.divisor  = DVS_W'(supply_q - mv_pos);
          state_d          = ST_DIV1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          ohms_d  = div_rsp.quotient;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        idx_d = '0;
        if ((ohms_q == '0) || (ohms_q > DIV_W'(rom_first)) ||
            (ohms_q < DIV_W'(rom_last))) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (seg_hit) begin
          pos_d   = rom_hi - ohms_q[ROM_W-1:0];
          span_d  = rom_hi - rom_lo;
          state_d = ST_FRAC;
        end else if (idx_q == LAST_SEG) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FRAC: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(pos_q) * DIV_W'(STEP_DECI_C) + DIV_W'(span_q >> 1);
        div_req.divisor  = DVS_W'(span_q);
        state_d          = ST_DIV2;
      end
      ST_DIV2: begin
        if (div_rsp.done) begin
          frac_d      = div_rsp.quotient[FRAC_W-1:0];
          lookup_ok_d = 1'b1;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // held temperature update at result time
  always_comb begin
    held_d = held_q;
    if (out_load) begin
      if (!range_ok_q) begin
        held_d = '0;
      end else if (lookup_ok_q) begin
        held_d = temp_calc;
      end
    end
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result payload flops
  always_ff @(posedge clk_i) begin
    mv_q        <= mv_d;
    ohms_q      <= ohms_d;
    idx_q       <= idx_d;
    pos_q       <= pos_d;
    span_q      <= span_d;
    frac_q      <= frac_d;
    range_ok_q  <= range_ok_d;
    lookup_ok_q <= lookup_ok_d;
    if (out_load) begin
      out_mv_q   <= mv_q;
      out_ohms_q <= range_ok_q ? ohms_q : '1;
      out_temp_q <= held_d;
      out_tv_q   <= range_ok_q & lookup_ok_q;
    end
  end

  // shared divider
  ntc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o           = (state_q != ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign sample_millivolts_o  = out_mv_q;
  assign thermistor_ohms_o    = out_ohms_q;
  assign temperature_deci_c_o = out_temp_q;
  assign temperature_valid_o  = out_tv_q;

`ifndef SYNTHESIS
  // divider never runs while the sequencer waits for an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while idle");

  // a valid temperature needs a positive voltage and a real resistance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && temperature_valid_o) |->
      (sample_millivolts_o > 14'sd0) && (thermistor_ohms_o != -30'sd1))
    else $error("valid temperature from out of range voltage");

  // out of range voltage reports a cleared temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (thermistor_ohms_o == -30'sd1)) |->
      (temperature_deci_c_o == 12'sd0) && !temperature_valid_o)
    else $error("out of range voltage did not clear temperature");
`endif

endmodule

`default_nettype wire
